// ----- rtl/core/dmxp_pkg.sv -----
// Shared types, codes and constants of the DMX USB frame parser.
// No dependencies; dmxp_universe, dmxp_reply and dmx_usb_frame_parser import this package.
package dmxp_pkg;

    localparam int CHAN_W = 9;
    localparam int UNIVERSE_SIZE_DEF = 512;
    localparam logic [7:0] START_CODE = 8'd126;
    localparam logic [7:0] END_CODE = 8'd231;
    localparam logic [7:0] DIFF_LABEL = 8'd100;
    localparam logic [3:0] TEXT_MAX = 4'd8;

    localparam logic [7:0] LBL_SEND = 8'd6;
    localparam logic [7:0] LBL_PARAMS = 8'd3;
    localparam logic [7:0] LBL_SERIAL = 8'd10;
    localparam logic [7:0] LBL_MAKER = 8'd77;
    localparam logic [7:0] LBL_NAME = 8'd78;

    localparam logic [7:0] PARAM_BYTE0 = 8'h09;
    localparam logic [7:0] PARAM_BYTE1 = 8'h02;
    localparam logic [7:0] PARAM_BYTE2 = 8'h28;

    localparam logic [1:0] FUNC_HOST = 2'd0;
    localparam logic [1:0] FUNC_LOCAL = 2'd1;
    localparam logic [1:0] FUNC_RD_PEND = 2'd2;
    localparam logic [1:0] FUNC_RD_ACT = 2'd3;

    localparam logic [1:0] KIND_REPLY = 2'd0;
    localparam logic [1:0] KIND_COMMIT = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] RSEL_SERIAL = 2'd0;
    localparam logic [1:0] RSEL_PARAMS = 2'd1;
    localparam logic [1:0] RSEL_MAKER = 2'd2;
    localparam logic [1:0] RSEL_NAME = 2'd3;

    localparam logic [2:0] REG_SERIAL = 3'd0;
    localparam logic [2:0] REG_FIRMWARE = 3'd1;
    localparam logic [2:0] REG_MAKER_ID = 3'd2;
    localparam logic [2:0] REG_DEVICE_ID = 3'd3;
    localparam logic [2:0] REG_MAKER_TEXT = 3'd4;
    localparam logic [2:0] REG_MAKER_LEN = 3'd5;
    localparam logic [2:0] REG_PRODUCT_TEXT = 3'd6;
    localparam logic [2:0] REG_PRODUCT_LEN = 3'd7;

    typedef struct packed {
        logic [31:0] serial_number;
        logic [15:0] firmware_version;
        logic [15:0] manufacturer_id;
        logic [15:0] device_ident;
        logic [63:0] maker_text;
        logic [3:0]  maker_text_length;
        logic [63:0] product_text;
        logic [3:0]  product_text_length;
    } cfg_t;

    typedef struct packed {
        logic              pend_we;
        logic [CHAN_W-1:0] pend_waddr;
        logic [7:0]        pend_wdata;
        logic              pend_re;
        logic [CHAN_W-1:0] pend_raddr;
        logic              act_we;
        logic [CHAN_W-1:0] act_waddr;
        logic [7:0]        act_wdata;
        logic              act_re;
        logic [CHAN_W-1:0] act_raddr;
    } mem_req_t;

endpackage

// ----- rtl/core/dmxp_ifs.sv -----
// Valid/ready channel interfaces for requests into and results out of the parser.
// No dependencies.
interface dmxp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] host_byte;
    logic       chunk_end;
    logic [8:0] channel;
    logic [7:0] level;

    modport source (output valid, func, host_byte, chunk_end, channel, level, input ready);
    modport sink (input valid, func, host_byte, chunk_end, channel, level, output ready);
endinterface

interface dmxp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, out_kind, out_byte, out_last, input ready);
    modport sink (input valid, out_kind, out_byte, out_last, output ready);
endinterface

// ----- rtl/core/dmxp_universe.sv -----
// Pending and active universe memories, one write and one registered read port each.
// Depends on dmxp_pkg.
module dmxp_universe
    import dmxp_pkg::*;
#(
    parameter int UNIVERSE_SIZE = UNIVERSE_SIZE_DEF
)
(
    input  logic       clk,
    input  mem_req_t   req,
    output logic [7:0] pend_rdata,
    output logic [7:0] act_rdata
);

    localparam int ADDR_W = (UNIVERSE_SIZE > 1) ? $clog2(UNIVERSE_SIZE) : 1;

    logic [7:0] pend_mem [UNIVERSE_SIZE];
    logic [7:0] act_mem [UNIVERSE_SIZE];

    always_ff @(posedge clk)
    begin
        if (req.pend_we)
        begin
            pend_mem[req.pend_waddr[ADDR_W-1:0]] <= req.pend_wdata;
        end
        if (req.pend_re)
        begin
            pend_rdata <= pend_mem[req.pend_raddr[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.act_we)
        begin
            act_mem[req.act_waddr[ADDR_W-1:0]] <= req.act_wdata;
        end
        if (req.act_re)
        begin
            act_rdata <= act_mem[req.act_raddr[ADDR_W-1:0]];
        end
    end

endmodule

// ----- rtl/core/dmxp_reply.sv -----
// Reply byte generator: gives the byte at a position of a query reply and its length.
// Depends on dmxp_pkg.
module dmxp_reply
    import dmxp_pkg::*;
(
    input  logic [1:0] rsel,
    input  logic [3:0] ridx,
    input  cfg_t       cfg,
    output logic [7:0] rbyte,
    output logic [3:0] rlen
);

    logic [3:0] maker_len;
    logic [3:0] product_len;
    logic [3:0] dlen;
    logic [7:0] label;
    logic [3:0] didx;
    logic [2:0] tidx;
    logic [7:0] dbyte;

    assign maker_len = (cfg.maker_text_length > TEXT_MAX) ? TEXT_MAX : cfg.maker_text_length;
    assign product_len = (cfg.product_text_length > TEXT_MAX) ? TEXT_MAX
                       : cfg.product_text_length;
    assign didx = ridx - 4'd4;
    assign tidx = 3'(didx - 4'd2);
    assign rlen = dlen + 4'd5;

    always_comb
    begin
        unique case (rsel)
            RSEL_SERIAL:
            begin
                dlen = 4'd4;
                label = LBL_SERIAL;
                dbyte = cfg.serial_number[8*didx[1:0] +: 8];
            end
            RSEL_PARAMS:
            begin
                dlen = 4'd5;
                label = LBL_PARAMS;
                priority case (didx)
                    4'd0: dbyte = cfg.firmware_version[7:0];
                    4'd1: dbyte = cfg.firmware_version[15:8];
                    4'd2: dbyte = PARAM_BYTE0;
                    4'd3: dbyte = PARAM_BYTE1;
                    default: dbyte = PARAM_BYTE2;
                endcase
            end
            RSEL_MAKER:
            begin
                dlen = maker_len + 4'd2;
                label = LBL_MAKER;
                priority if (didx == 4'd0)
                    dbyte = cfg.manufacturer_id[7:0];
                else if (didx == 4'd1)
                    dbyte = cfg.manufacturer_id[15:8];
                else
                    dbyte = cfg.maker_text[8*tidx +: 8];
            end
            default:
            begin
                dlen = product_len + 4'd2;
                label = LBL_NAME;
                priority if (didx == 4'd0)
                    dbyte = cfg.device_ident[7:0];
                else if (didx == 4'd1)
                    dbyte = cfg.device_ident[15:8];
                else
                    dbyte = cfg.product_text[8*tidx +: 8];
            end
        endcase
    end

    always_comb
    begin
        priority if (ridx == rlen - 4'd1)
            rbyte = END_CODE;
        else if (ridx == 4'd0)
            rbyte = START_CODE;
        else if (ridx == 4'd1)
            rbyte = label;
        else if (ridx == 4'd2)
            rbyte = {4'd0, dlen};
        else if (ridx == 4'd3)
            rbyte = 8'd0;
        else
            rbyte = dbyte;
    end

endmodule

// ----- rtl/core/dmx_usb_frame_parser.sv -----
// Host frame parser with pending and active DMX universes and query replies.
// Depends on dmxp_pkg, dmxp_ifs, dmxp_universe and dmxp_reply.
//
// After reset the block clears both universes, one channel per cycle, before
// it takes the first request. A query reply sends one byte per cycle while the
// output register is free, seven to fifteen bytes. A commit copies the pending
// universe into the active one through the memory read port, one channel per
// cycle, and then loads its result. A channel read waits in S_RDOUT for the
// registered memory read before it loads its result. Results wait in a single
// output register.
module dmx_usb_frame_parser
    import dmxp_pkg::*;
#(
    parameter int UNIVERSE_SIZE = UNIVERSE_SIZE_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    dmxp_in_if.sink      request,
    dmxp_out_if.source   result,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam int CNT_W = $clog2(UNIVERSE_SIZE + 1);
    localparam logic [15:0] NCH = 16'(UNIVERSE_SIZE);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_LABEL = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_END = 3'd5;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RDOUT = 3'd2;
    localparam logic [2:0] S_REPLY = 3'd3;
    localparam logic [2:0] S_COPY = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    cfg_t cfg_reg;

    logic [2:0]  state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] cnt_m1;
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  label_reg, label_next;
    logic [15:0] plen_reg, plen_next;
    logic [15:0] pcount_reg, pcount_next;
    logic        diff_reg, diff_next;
    logic [1:0]  tphase_reg, tphase_next;
    logic [15:0] target_reg, target_next;
    logic        upd_reg, upd_next;
    logic [1:0]  rsel_reg, rsel_next;
    logic [3:0]  ridx_reg, ridx_next;
    logic        cafter_reg, cafter_next;
    logic        rdact_reg, rdact_next;
    logic        oor_reg, oor_next;
    logic        ov_reg, ov_next;
    logic [1:0]  okind_reg, okind_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;

    logic [2:0]  p_phase;
    logic [7:0]  p_label;
    logic [15:0] p_plen;
    logic [15:0] p_pcount;
    logic        p_diff;
    logic [1:0]  p_tphase;
    logic [15:0] p_target;
    logic        p_upd;
    logic        p_we;
    logic [15:0] p_waddr;
    logic        p_reply;
    logic [1:0]  p_rsel;
    logic [1:0]  t_inc;
    logic [15:0] cnt_inc;
    logic        commit_now;
    logic        ch_ok;

    mem_req_t    mreq;
    logic [7:0]  pend_rdata;
    logic [7:0]  act_rdata;
    logic [7:0]  r_byte;
    logic [3:0]  r_len;
    logic        can_load;

    dmxp_universe #(
        .UNIVERSE_SIZE(UNIVERSE_SIZE)
    ) u_universe (
        .clk       (clk),
        .req       (mreq),
        .pend_rdata(pend_rdata),
        .act_rdata (act_rdata)
    );

    dmxp_reply u_reply (
        .rsel (rsel_reg),
        .ridx (ridx_reg),
        .cfg  (cfg_reg),
        .rbyte(r_byte),
        .rlen (r_len)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SERIAL:       cfg_reg.serial_number <= cfg_data[31:0];
                REG_FIRMWARE:     cfg_reg.firmware_version <= cfg_data[15:0];
                REG_MAKER_ID:     cfg_reg.manufacturer_id <= cfg_data[15:0];
                REG_DEVICE_ID:    cfg_reg.device_ident <= cfg_data[15:0];
                REG_MAKER_TEXT:   cfg_reg.maker_text <= cfg_data;
                REG_MAKER_LEN:    cfg_reg.maker_text_length <= cfg_data[3:0];
                REG_PRODUCT_TEXT: cfg_reg.product_text <= cfg_data;
                default:          cfg_reg.product_text_length <= cfg_data[3:0];
            endcase
        end
    end

    assign t_inc = tphase_reg + 2'd1;
    assign cnt_inc = pcount_reg + 16'd1;
    assign ch_ok = {7'd0, request.channel} < NCH;
    assign cnt_m1 = cnt_reg - CNT_W'(1);
    assign can_load = !ov_reg || result.ready;

    // Parser step for one host byte.
    always_comb
    begin
        p_phase = phase_reg;
        p_label = label_reg;
        p_plen = plen_reg;
        p_pcount = pcount_reg;
        p_diff = diff_reg;
        p_tphase = tphase_reg;
        p_target = target_reg;
        p_upd = upd_reg;
        p_we = 1'b0;
        p_waddr = pcount_reg;
        p_reply = 1'b0;
        p_rsel = RSEL_SERIAL;
        unique case (phase_reg)
            PH_START:
            begin
                if (request.host_byte == START_CODE)
                    p_phase = PH_LABEL;
            end
            PH_LABEL:
            begin
                p_label = request.host_byte;
                if (request.host_byte == LBL_SEND || request.host_byte == DIFF_LABEL)
                begin
                    p_phase = PH_LEN_LO;
                    if (request.host_byte == DIFF_LABEL)
                        p_diff = 1'b1;
                end
                else
                begin
                    p_phase = PH_END;
                end
            end
            PH_LEN_LO:
            begin
                p_plen = {8'd0, request.host_byte};
                p_phase = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                p_plen = {request.host_byte, plen_reg[7:0]};
                p_pcount = 16'd0;
                p_phase = (p_plen != 16'd0) ? PH_DATA : PH_END;
            end
            PH_DATA:
            begin
                if (diff_reg)
                begin
                    p_tphase = t_inc;
                    if (t_inc == 2'd1)
                    begin
                        p_target = {8'd0, request.host_byte};
                    end
                    else if (t_inc == 2'd2)
                    begin
                        p_target = target_reg | {request.host_byte, 8'd0};
                    end
                    else if (t_inc == 2'd3)
                    begin
                        p_tphase = 2'd0;
                        p_waddr = target_reg;
                        p_we = 1'b1;
                    end
                end
                else
                begin
                    p_we = 1'b1;
                end
                p_pcount = cnt_inc;
                if (cnt_inc == plen_reg)
                    p_phase = PH_END;
            end
            PH_END:
            begin
                if (request.host_byte == END_CODE)
                begin
                    p_phase = PH_START;
                    priority if (label_reg == LBL_SEND)
                    begin
                        p_upd = 1'b1;
                    end
                    else if (label_reg == LBL_SERIAL)
                    begin
                        p_reply = 1'b1;
                        p_rsel = RSEL_SERIAL;
                    end
                    else if (label_reg == LBL_PARAMS)
                    begin
                        p_reply = 1'b1;
                        p_rsel = RSEL_PARAMS;
                    end
                    else if (label_reg == LBL_MAKER)
                    begin
                        p_reply = 1'b1;
                        p_rsel = RSEL_MAKER;
                    end
                    else if (label_reg == LBL_NAME)
                    begin
                        p_reply = 1'b1;
                        p_rsel = RSEL_NAME;
                    end
                end
                p_target = 16'd0;
                p_tphase = 2'd0;
                p_diff = 1'b0;
            end
            default:
            begin
                p_phase = PH_START;
            end
        endcase
        if (p_we && p_waddr >= NCH)
            p_we = 1'b0;
        if (p_we)
            p_upd = 1'b1;
    end

    assign commit_now = request.chunk_end && p_upd;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        phase_next = phase_reg;
        label_next = label_reg;
        plen_next = plen_reg;
        pcount_next = pcount_reg;
        diff_next = diff_reg;
        tphase_next = tphase_reg;
        target_next = target_reg;
        upd_next = upd_reg;
        rsel_next = rsel_reg;
        ridx_next = ridx_reg;
        cafter_next = cafter_reg;
        rdact_next = rdact_reg;
        oor_next = oor_reg;
        okind_next = okind_reg;
        obyte_next = obyte_reg;
        olast_next = olast_reg;
        ov_next = ov_reg && !result.ready;
        request.ready = 1'b0;
        mreq = '0;
        mreq.pend_raddr = request.channel;
        mreq.act_raddr = request.channel;
        unique case (state_reg)
            S_CLEAR:
            begin
                mreq.pend_we = 1'b1;
                mreq.act_we = 1'b1;
                mreq.pend_waddr = CHAN_W'(cnt_reg);
                mreq.act_waddr = CHAN_W'(cnt_reg);
                if (cnt_reg == CNT_W'(UNIVERSE_SIZE - 1))
                begin
                    cnt_next = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    unique case (request.func)
                        FUNC_HOST:
                        begin
                            phase_next = p_phase;
                            label_next = p_label;
                            plen_next = p_plen;
                            pcount_next = p_pcount;
                            diff_next = p_diff;
                            tphase_next = p_tphase;
                            target_next = p_target;
                            upd_next = commit_now ? 1'b0 : p_upd;
                            mreq.pend_we = p_we;
                            mreq.pend_waddr = CHAN_W'(p_waddr);
                            mreq.pend_wdata = request.host_byte;
                            cnt_next = '0;
                            if (p_reply)
                            begin
                                rsel_next = p_rsel;
                                ridx_next = 4'd0;
                                cafter_next = commit_now;
                                state_next = S_REPLY;
                            end
                            else if (commit_now)
                            begin
                                state_next = S_COPY;
                            end
                        end
                        FUNC_LOCAL:
                        begin
                            mreq.pend_we = ch_ok;
                            mreq.pend_waddr = request.channel;
                            mreq.pend_wdata = request.level;
                            upd_next = 1'b0;
                            cnt_next = '0;
                            state_next = S_COPY;
                        end
                        default:
                        begin
                            rdact_next = (request.func == FUNC_RD_ACT);
                            mreq.pend_re = (request.func == FUNC_RD_PEND);
                            mreq.act_re = (request.func == FUNC_RD_ACT);
                            oor_next = !ch_ok;
                            state_next = S_RDOUT;
                        end
                    endcase
                end
            end
            S_RDOUT:
            begin
                if (can_load)
                begin
                    ov_next = 1'b1;
                    okind_next = KIND_READ;
                    obyte_next = oor_reg ? 8'd0 : (rdact_reg ? act_rdata : pend_rdata);
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_REPLY:
            begin
                if (can_load)
                begin
                    ov_next = 1'b1;
                    okind_next = KIND_REPLY;
                    obyte_next = r_byte;
                    olast_next = (ridx_reg == r_len - 4'd1) && !cafter_reg;
                    if (ridx_reg == r_len - 4'd1)
                    begin
                        cnt_next = '0;
                        state_next = cafter_reg ? S_COPY : S_IDLE;
                    end
                    else
                    begin
                        ridx_next = ridx_reg + 4'd1;
                    end
                end
            end
            S_COPY:
            begin
                mreq.pend_re = (cnt_reg != CNT_W'(UNIVERSE_SIZE));
                mreq.pend_raddr = CHAN_W'(cnt_reg);
                mreq.act_we = (cnt_reg != '0);
                mreq.act_waddr = CHAN_W'(cnt_m1);
                mreq.act_wdata = pend_rdata;
                if (cnt_reg == CNT_W'(UNIVERSE_SIZE))
                    state_next = S_COMMIT;
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            S_COMMIT:
            begin
                if (can_load)
                begin
                    ov_next = 1'b1;
                    okind_next = KIND_COMMIT;
                    obyte_next = 8'd0;
                    olast_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            phase_reg <= PH_START;
            label_reg <= '0;
            plen_reg <= '0;
            pcount_reg <= '0;
            diff_reg <= 1'b0;
            tphase_reg <= '0;
            target_reg <= '0;
            upd_reg <= 1'b0;
            rsel_reg <= RSEL_SERIAL;
            ridx_reg <= '0;
            cafter_reg <= 1'b0;
            rdact_reg <= 1'b0;
            oor_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            phase_reg <= phase_next;
            label_reg <= label_next;
            plen_reg <= plen_next;
            pcount_reg <= pcount_next;
            diff_reg <= diff_next;
            tphase_reg <= tphase_next;
            target_reg <= target_next;
            upd_reg <= upd_next;
            rsel_reg <= rsel_next;
            ridx_reg <= ridx_next;
            cafter_reg <= cafter_next;
            rdact_reg <= rdact_next;
            oor_reg <= oor_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        okind_reg <= okind_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
    end

    assign result.valid = ov_reg;
    assign result.out_kind = okind_reg;
    assign result.out_byte = obyte_reg;
    assign result.out_last = olast_reg;

    a_copy_clears_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COPY |-> !upd_reg)
        else $error("update mark still set during commit copy");

    a_commit_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMMIT |-> cnt_reg == CNT_W'(UNIVERSE_SIZE))
        else $error("commit result before the copy sweep finished");

    a_reply_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REPLY |-> ridx_reg < r_len)
        else $error("reply index past the reply length");

    a_no_request_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !request.ready)
        else $error("request taken during the clearing pass");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |=> $stable(result.out_byte))
        else $error("pending result overwritten");

endmodule
